// ===== rtl/core/tkjp_pkg.sv =====
// shared types and constants for the two-key json line parser
// character codes, parse phase enum, character class and result structs
// no dependencies
package tkjp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BYTE_WIDTH  = 8;
	localparam int DIGIT_WIDTH = 4;

	// magnitude holds up to 2^(VALUE_WIDTH-1), which still fits VALUE_WIDTH unsigned bits
	localparam logic [VALUE_WIDTH-1:0] MAG_CAP   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] CAP_DIV10 = MAG_CAP / 10;
	localparam logic [DIGIT_WIDTH-1:0] CAP_MOD10 = DIGIT_WIDTH'(MAG_CAP % 10);

	localparam logic [BYTE_WIDTH-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_WIDTH-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_WIDTH-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_WIDTH-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_WIDTH-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_WIDTH-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_WIDTH-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_WIDTH-1:0] CH_V      = 8'h76;
	localparam logic [BYTE_WIDTH-1:0] CH_W      = 8'h77;
	localparam logic [BYTE_WIDTH-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_WIDTH-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_WIDTH-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_WIDTH-1:0] CH_VT     = 8'h0B;
	localparam logic [BYTE_WIDTH-1:0] CH_FF     = 8'h0C;
	localparam logic [BYTE_WIDTH-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_WIDTH-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_WIDTH-1:0] CH_NINE   = 8'h39;

	localparam logic KEY_V = 1'b0;
	localparam logic KEY_W = 1'b1;

	typedef enum logic [3:0] {
		PH_OPEN         = 4'd0,
		PH_KEY_OR_CLOSE = 4'd1,
		PH_KEY_LETTER   = 4'd2,
		PH_KEY_QUOTE    = 4'd3,
		PH_COLON        = 4'd4,
		PH_NUM_START    = 4'd5,
		PH_NUM_SIGNED   = 4'd6,
		PH_DIGITS       = 4'd7,
		PH_AFTER_VALUE  = 4'd8,
		PH_DONE_OK      = 4'd9,
		PH_DONE_BAD     = 4'd10
	} phase_t;

	typedef struct packed {
		logic                   gap;
		logic                   num_gap;
		logic                   digit;
		logic                   lbrace;
		logic                   rbrace;
		logic                   quote;
		logic                   colon;
		logic                   comma;
		logic                   plus;
		logic                   minus;
		logic                   key_v;
		logic                   key_w;
		logic [DIGIT_WIDTH-1:0] digit_val;
	} char_class_t;

	typedef struct packed {
		logic                          accepted;
		logic signed [VALUE_WIDTH-1:0] throttle_value;
		logic signed [VALUE_WIDTH-1:0] turn_value;
	} line_result_t;

endpackage

// ===== rtl/core/tkjp_char_class.sv =====
// byte classifier for the two-key json line parser
// depends on tkjp_pkg
module tkjp_char_class
	import tkjp_pkg::*;
(
	input  logic [BYTE_WIDTH-1:0] in_byte,
	output char_class_t           cls
);

	logic [BYTE_WIDTH-1:0] digit_off;

	assign digit_off = in_byte - CH_ZERO;

	always_comb begin
		cls.gap       = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
		                (in_byte == CH_CR) || (in_byte == CH_LF);
		cls.num_gap   = cls.gap || (in_byte == CH_VT) || (in_byte == CH_FF);
		cls.digit     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		cls.lbrace    = (in_byte == CH_LBRACE);
		cls.rbrace    = (in_byte == CH_RBRACE);
		cls.quote     = (in_byte == CH_QUOTE);
		cls.colon     = (in_byte == CH_COLON);
		cls.comma     = (in_byte == CH_COMMA);
		cls.plus      = (in_byte == CH_PLUS);
		cls.minus     = (in_byte == CH_MINUS);
		cls.key_v     = (in_byte == CH_V);
		cls.key_w     = (in_byte == CH_W);
		cls.digit_val = digit_off[DIGIT_WIDTH-1:0];
	end

endmodule

// ===== rtl/core/tkjp_num_acc.sv =====
// saturating decimal accumulator and signed value conversion
// depends on tkjp_pkg
module tkjp_num_acc
	import tkjp_pkg::*;
(
	input  logic [VALUE_WIDTH-1:0]        magnitude,
	input  logic [DIGIT_WIDTH-1:0]        digit_val,
	input  logic                          is_negative,
	output logic [VALUE_WIDTH-1:0]        magnitude_next,
	output logic signed [VALUE_WIDTH-1:0] value
);

	logic over;

	// same as magnitude > (cap - digit) / 10 without a divider
	assign over = (magnitude > CAP_DIV10) ||
	              ((magnitude == CAP_DIV10) && (digit_val > CAP_MOD10));

	always_comb begin
		if (over) begin
			magnitude_next = MAG_CAP;
		end else begin
			magnitude_next = (magnitude << 3) + (magnitude << 1) +
			                 VALUE_WIDTH'(digit_val);
		end
	end

	// top bit set means the magnitude reached the cap
	always_comb begin
		if (is_negative) begin
			value = $signed(-magnitude);
		end else if (magnitude[VALUE_WIDTH-1]) begin
			value = $signed(MAG_CAP - VALUE_WIDTH'(1));
		end else begin
			value = $signed(magnitude);
		end
	end

endmodule

// ===== rtl/core/tkjp_parser.sv =====
// parse state machine and held values for the two-key json line parser
// depends on tkjp_pkg, tkjp_char_class, tkjp_num_acc
module tkjp_parser
	import tkjp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [BYTE_WIDTH-1:0] in_byte,
	input  logic                  line_end,
	output line_result_t          result
);

	phase_t                        phase_q, phase_d;
	logic                          key_q, key_d;
	logic                          neg_q, neg_d;
	logic [VALUE_WIDTH-1:0]        mag_q, mag_d;
	logic                          seen_v_q, seen_v_d;
	logic                          seen_w_q, seen_w_d;
	logic signed [VALUE_WIDTH-1:0] held_v_q, held_v_d;
	logic signed [VALUE_WIDTH-1:0] held_w_q, held_w_d;

	char_class_t                   cls;
	logic [VALUE_WIDTH-1:0]        mag_acc;
	logic signed [VALUE_WIDTH-1:0] commit_val;
	logic                          commit;
	logic                          both_seen;
	logic                          line_ok;

	tkjp_char_class u_class (
		.in_byte (in_byte),
		.cls     (cls)
	);

	tkjp_num_acc u_acc (
		.magnitude      (mag_q),
		.digit_val      (cls.digit_val),
		.is_negative    (neg_q),
		.magnitude_next (mag_acc),
		.value          (commit_val)
	);

	// a value ends on the first non-digit in the digit phase
	assign commit = (phase_q == PH_DIGITS) && !cls.digit;

	always_comb begin
		seen_v_d = seen_v_q;
		seen_w_d = seen_w_q;
		held_v_d = held_v_q;
		held_w_d = held_w_q;
		if (commit) begin
			if (key_q == KEY_W) begin
				seen_w_d = 1'b1;
				held_w_d = commit_val;
			end else begin
				seen_v_d = 1'b1;
				held_v_d = commit_val;
			end
		end
	end

	assign both_seen = seen_v_d && seen_w_d;

	always_comb begin
		phase_d = PH_DONE_BAD;
		key_d   = key_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		unique case (phase_q)
			PH_OPEN: begin
				if (cls.gap) phase_d = PH_OPEN;
				else if (cls.lbrace) phase_d = PH_KEY_OR_CLOSE;
			end
			PH_KEY_OR_CLOSE: begin
				if (cls.gap) phase_d = PH_KEY_OR_CLOSE;
				else if (cls.rbrace) phase_d = both_seen ? PH_DONE_OK : PH_DONE_BAD;
				else if (cls.quote) phase_d = PH_KEY_LETTER;
			end
			PH_KEY_LETTER: begin
				if (cls.key_v) begin
					key_d   = KEY_V;
					phase_d = PH_KEY_QUOTE;
				end else if (cls.key_w) begin
					key_d   = KEY_W;
					phase_d = PH_KEY_QUOTE;
				end
			end
			PH_KEY_QUOTE: begin
				if (cls.quote) phase_d = PH_COLON;
			end
			PH_COLON: begin
				if (cls.gap) begin
					phase_d = PH_COLON;
				end else if (cls.colon) begin
					neg_d   = 1'b0;
					mag_d   = '0;
					phase_d = PH_NUM_START;
				end
			end
			PH_NUM_START: begin
				if (cls.num_gap) begin
					phase_d = PH_NUM_START;
				end else if (cls.plus) begin
					phase_d = PH_NUM_SIGNED;
				end else if (cls.minus) begin
					neg_d   = 1'b1;
					phase_d = PH_NUM_SIGNED;
				end else if (cls.digit) begin
					mag_d   = mag_acc;
					phase_d = PH_DIGITS;
				end
			end
			PH_NUM_SIGNED: begin
				if (cls.digit) begin
					mag_d   = mag_acc;
					phase_d = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (cls.digit) begin
					mag_d   = mag_acc;
					phase_d = PH_DIGITS;
				end else if (cls.gap) phase_d = PH_AFTER_VALUE;
				else if (cls.comma) phase_d = PH_KEY_OR_CLOSE;
				else if (cls.rbrace) phase_d = both_seen ? PH_DONE_OK : PH_DONE_BAD;
			end
			PH_AFTER_VALUE: begin
				if (cls.gap) phase_d = PH_AFTER_VALUE;
				else if (cls.comma) phase_d = PH_KEY_OR_CLOSE;
				else if (cls.rbrace) phase_d = both_seen ? PH_DONE_OK : PH_DONE_BAD;
			end
			PH_DONE_OK: phase_d = PH_DONE_OK;
			default:    phase_d = PH_DONE_BAD;
		endcase
	end

	assign line_ok = (phase_d == PH_DONE_OK);

	always_comb begin
		result.accepted       = line_ok;
		result.throttle_value = line_ok ? held_v_d : '0;
		result.turn_value     = line_ok ? held_w_d : '0;
	end

	// the line end byte returns everything to the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPEN;
			key_q    <= KEY_V;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			seen_v_q <= 1'b0;
			seen_w_q <= 1'b0;
			held_v_q <= '0;
			held_w_q <= '0;
		end else if (step) begin
			if (line_end) begin
				phase_q  <= PH_OPEN;
				key_q    <= KEY_V;
				neg_q    <= 1'b0;
				mag_q    <= '0;
				seen_v_q <= 1'b0;
				seen_w_q <= 1'b0;
				held_v_q <= '0;
				held_w_q <= '0;
			end else begin
				phase_q  <= phase_d;
				key_q    <= key_d;
				neg_q    <= neg_d;
				mag_q    <= mag_d;
				seen_v_q <= seen_v_d;
				seen_w_q <= seen_w_d;
				held_v_q <= held_v_d;
				held_w_q <= held_w_d;
			end
		end
	end

endmodule

// ===== rtl/core/two_key_json_line_parser.sv =====
// Parses a command line of the form {"v":N,"w":M} one byte per transfer and
// returns one result on the byte marked with tlast: the accept flag plus the
// last values given for keys v and w, saturated to 32-bit signed (both zero
// when the line is rejected). A byte passes an input register and is then
// parsed by the state machine, whose result lands in an output register, so
// a tlast byte reaches its result through both registers; the parser takes one
// byte every cycle while the input does not stall. The input stalls only when
// a line end byte waits for the output register to be taken.
// depends on tkjp_pkg, tkjp_parser
module two_key_json_line_parser
	import tkjp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [BYTE_WIDTH-1:0]      s_axis_tdata,  // [7:0] in_byte
	input  logic                       s_axis_tlast,  // line_end
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [2*VALUE_WIDTH-1:0]   m_axis_tdata,  // [31:0] throttle_value, [63:32] turn_value
	output logic                       m_axis_tuser   // accepted
);

	logic                  valid_s1;
	logic [BYTE_WIDTH-1:0] byte_s1;
	logic                  last_s1;
	logic                  fire_s1;
	line_result_t          result;
	line_result_t          out_q;
	logic                  out_valid_q;

	// only a line end byte needs room in the output register
	assign fire_s1       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	tkjp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (fire_s1),
		.in_byte  (byte_s1),
		.line_end (last_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.turn_value, out_q.throttle_value};
	assign m_axis_tuser  = out_q.accepted;

	// a new result appears only after a line end byte was parsed
	a_result_from_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(fire_s1 && last_s1))
		else $error("result without a parsed line end");

	// rejected lines carry zero values
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("rejected line with nonzero values");

	// the input stalls only behind a waiting result
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a pending result");

endmodule
